>>> hw/rtl/tcce_pkg.sv
package tcce_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int STOP_W = $clog2(COLUMNS + TAB_WIDTH + 1);

  // Port field widths
  localparam int ACT_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int IDX_W   = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } tcce_action_e;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_PRIME,
    ST_SWEEP,
    ST_DONE
  } tcce_state_e;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [CELL_W-1:0]   wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } tcce_mem_req_t;

  typedef logic [STOP_W-1:0] tab_stop_t [COLUMNS];

  function automatic tab_stop_t build_tab_stops();
    tab_stop_t t;
    for (int i = 0; i < COLUMNS; i++) begin
      t[i] = STOP_W'((i / TAB_WIDTH + 1) * TAB_WIDTH);
    end
    return t;
  endfunction

  // Next tab stop for each column
  localparam tab_stop_t TAB_STOPS = build_tab_stops();

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

>>> hw/rtl/tcce_in_if.sv
interface tcce_in_if import tcce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] color;
  logic [IDX_W-1:0]   cell_index;

  modport source (output valid, action, char_code, color, cell_index, input ready);
  modport sink   (input valid, action, char_code, color, cell_index, output ready);
endinterface

>>> hw/rtl/tcce_out_if.sv
interface tcce_out_if import tcce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   cursor_pos;
  logic [CHAR_W-1:0]  cell_char;
  logic [COLOR_W-1:0] cell_color;

  modport source (output valid, cursor_pos, cell_char, cell_color, input ready);
  modport sink   (input valid, cursor_pos, cell_char, cell_color, output ready);
endinterface

>>> hw/rtl/tcce_store.sv
module tcce_store import tcce_pkg::*; (
  input  logic               clk_i,
  input  tcce_mem_req_t      mem_req_i,
  output logic [CELL_W-1:0]  rdata_o
);

  logic [CELL_W-1:0] mem_q [CELLS];
  logic [CELL_W-1:0] rdata_q;

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tcce_ctrl.sv
module tcce_ctrl import tcce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tcce_in_if.sink            in_i,
  tcce_out_if.source         out_o,
  output tcce_mem_req_t      mem_req_o,
  input  logic [CELL_W-1:0]  mem_rdata_i
);

  tcce_state_e state_q, state_d;

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0]  bs_addr_q, bs_addr_d;
  logic               copy_q, copy_d;
  logic               emit_q, emit_d;
  logic               rd_sel_q, rd_sel_d;
  logic               out_valid_q, out_valid_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic [COLOR_W-1:0] out_color_q, out_color_d;

  logic               accept;
  logic               out_free;
  logic               idx_ok;
  logic               sweep_last;
  logic               copy_src;
  logic [ADDR_W-1:0]  cur_addr;
  tcce_action_e       action;

  logic [STOP_W-1:0]  put_col;
  logic [COL_W-1:0]   put_col_fin;
  logic [ROW_W-1:0]   put_row;
  logic               put_scroll;
  logic               put_bs;
  logic               put_print;

  assign action     = tcce_action_e'(in_i.action);
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign cur_addr   = cell_addr(row_q, col_q);
  assign idx_ok     = 32'(in_i.cell_index) < CELLS;
  assign sweep_last = (cnt_q == ADDR_W'(CELLS - 1));
  // During a scroll the last row is filled with blanks, not copied
  assign copy_src   = copy_q && (32'(cnt_q) < CELLS - COLUMNS);

  // Cursor movement for a put, wrap and scroll included
  always_comb begin
    put_bs    = 1'b0;
    put_print = 1'b1;
    put_col   = STOP_W'(col_q) + STOP_W'(1);
    put_row   = row_q;
    case (in_i.char_code)
      CH_BS: begin
        put_bs    = 1'b1;
        put_print = 1'b0;
        put_col   = STOP_W'(col_q);
      end
      CH_TAB: begin
        put_print = 1'b0;
        put_col   = TAB_STOPS[col_q];
      end
      CH_CR: begin
        put_print = 1'b0;
        put_col   = '0;
      end
      CH_LF: begin
        put_print = 1'b0;
        put_col   = '0;
        put_row   = row_q + ROW_W'(1);
      end
      default: ;
    endcase
    if (32'(put_col) >= COLUMNS) begin
      put_col = '0;
      put_row = row_q + ROW_W'(1);
    end
    put_scroll = 32'(put_row) >= ROWS - 1;
    if (put_scroll) begin
      put_row = ROW_W'(ROWS - 2);
    end
    put_col_fin = COL_W'(put_col);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_PUT: begin
              if (put_bs) begin
                state_d = (col_q != '0) ? ST_RMW : ST_DONE;
              end else begin
                state_d = put_scroll ? ST_PRIME : ST_DONE;
              end
            end
            ACT_CLEAR: state_d = ST_SWEEP;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_RMW:   state_d = ST_DONE;
      ST_PRIME: state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = emit_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Store accesses and register updates
  always_comb begin
    mem_req_o   = '0;
    col_d       = col_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    bs_addr_d   = bs_addr_q;
    copy_d      = copy_q;
    emit_d      = emit_q;
    rd_sel_d    = rd_sel_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_pos_d   = out_pos_q;
    out_char_d  = out_char_q;
    out_color_d = out_color_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_sel_d = 1'b0;
          emit_d   = 1'b1;
          cnt_d    = '0;
          unique case (action)
            ACT_PUT: begin
              if (put_bs) begin
                if (col_q != '0) begin
                  col_d           = col_q - COL_W'(1);
                  bs_addr_d       = cur_addr - ADDR_W'(1);
                  mem_req_o.re    = 1'b1;
                  mem_req_o.raddr = cur_addr - ADDR_W'(1);
                end
              end else begin
                if (put_print) begin
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = cur_addr;
                  mem_req_o.wdata = {in_i.color, in_i.char_code};
                end
                col_d  = put_col_fin;
                row_d  = put_row;
                copy_d = 1'b1;
              end
            end
            ACT_CLEAR: begin
              col_d  = '0;
              row_d  = '0;
              copy_d = 1'b0;
            end
            ACT_READ: begin
              if (idx_ok) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = ADDR_W'(in_i.cell_index);
                rd_sel_d        = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        // backspace blanks the character, keeps the colour
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = bs_addr_q;
        mem_req_o.wdata = {mem_rdata_i[CELL_W-1:CHAR_W], CHAR_W'(0)};
      end
      ST_PRIME: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = ADDR_W'(COLUMNS);
      end
      ST_SWEEP: begin
        // write cell n while fetching the source of cell n+1
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cnt_q;
        mem_req_o.wdata = copy_src ? mem_rdata_i : '0;
        mem_req_o.re    = copy_q && (32'(cnt_q) + 1 < CELLS - COLUMNS);
        mem_req_o.raddr = ADDR_W'(32'(cnt_q) + 1 + COLUMNS);
        cnt_d           = cnt_q + ADDR_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = POS_W'(cur_addr);
          out_char_d  = rd_sel_q ? mem_rdata_i[CHAR_W-1:0] : '0;
          out_color_d = rd_sel_q ? mem_rdata_i[CELL_W-1:CHAR_W] : '0;
        end
      end
      default: ;
    endcase
  end

  // Reset starts with a clearing pass over the store, no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      copy_q      <= 1'b0;
      emit_q      <= 1'b0;
      rd_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      copy_q      <= copy_d;
      emit_q      <= emit_d;
      rd_sel_q    <= rd_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bs_addr_q   <= bs_addr_d;
    out_pos_q   <= out_pos_d;
    out_char_q  <= out_char_d;
    out_color_q <= out_color_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cursor_pos = out_pos_q;
  assign out_o.cell_char  = out_char_q;
  assign out_o.cell_color = out_color_q;

endmodule

>>> hw/rtl/text_console_cursor_engine.sv
// Text console engine: an 80x25 store of 16-bit cells (character in the low
// byte, colour in the high byte) and a cursor, all cells held in one
// single-port-write, one-read synchronous RAM. Each request gives exactly one
// response carrying the linear cursor position row*80+col after the request;
// a read request also returns the addressed cell (zero when out of range).
// A backspace is a read-modify-write through the RAM ports; a backspace at
// column zero touches nothing. A put that scrolls primes the first read and
// then sweeps the RAM, and a clear sweeps it too; both walk the whole RAM one
// cell a cycle. After reset the engine runs a clearing pass before it takes
// its first request. The input is taken again as soon as the response is
// registered, so a response may wait at the output while the next request is
// already in progress.
module text_console_cursor_engine import tcce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcce_in_if.sink    in_i,
  tcce_out_if.source out_o
);

  tcce_mem_req_t     mem_req;
  logic [CELL_W-1:0] mem_rdata;

  // Cursor, sequencing of put/scroll/clear and response register
  tcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Character/colour store
  tcce_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

endmodule

>>> tb/text_console_cursor_engine_tb.sv
`timescale 1ns / 1ps

// Stimulus runs ahead of the engine through a short queue of requests. The
// console state is mirrored here and updated as each request is taken, and
// every response is checked against the oldest outstanding prediction.
module text_console_cursor_engine_tb;
  import tcce_pkg::*;

  localparam int IDLE_LIMIT  = 20000;  // clearing pass, a full walk, stalls
  localparam int TAIL_CYCLES = 2100;   // one walk of the store after the end
  localparam int RANDOM_REQS = 1376;
  localparam int REQ_DEPTH   = 4;

  typedef struct {
    tcce_action_e       action;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   cell_index;
    bit                 drain;  // hold until every response is back
  } console_req_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] colr;
  } console_resp_t;

  logic clk;
  logic rst_n = 1'b0;

  // Inputs of the engine, known from time zero
  logic               req_valid  = 1'b0;
  tcce_action_e       req_action = ACT_PUT;
  logic [CHAR_W-1:0]  req_char   = '0;
  logic [COLOR_W-1:0] req_color  = '0;
  logic [IDX_W-1:0]   req_index  = '0;
  logic               rsp_ready  = 1'b0;

  tcce_in_if  in_bus ();
  tcce_out_if out_bus ();

  assign in_bus.valid      = req_valid;
  assign in_bus.action     = req_action;
  assign in_bus.char_code  = req_char;
  assign in_bus.color      = req_color;
  assign in_bus.cell_index = req_index;
  assign out_bus.ready     = rsp_ready;

  text_console_cursor_engine dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the console: cell store (colour high byte, character low byte)
  // and the cursor.
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] screen_mirror [CELLS];
  int                cur_col;
  int                cur_row;

  console_req_t  req_q [$];      // requests waiting for the driver
  console_resp_t cursor_exp_q [$];  // predicted responses, oldest first
  int            err_count;

  initial begin
    foreach (screen_mirror[i]) screen_mirror[i] = '0;
    cur_col   = 0;
    cur_row   = 0;
    err_count = 0;
  end

  // Applies one request to the mirror and returns the response it predicts.
  function automatic console_resp_t console_apply(input console_req_t r);
    console_resp_t res;
    int            slot;
    res = '0;
    case (r.action)
      ACT_PUT: begin
        case (r.char_code)
          CH_BS: begin
            // backspace at column zero does nothing
            if (cur_col > 0) begin
              cur_col--;
              slot = cur_row * COLUMNS + cur_col;
              screen_mirror[slot][CHAR_W-1:0] = '0;  // colour byte stays
            end
          end
          CH_TAB: cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
          CH_CR:  cur_col = 0;
          CH_LF: begin
            cur_col = 0;
            cur_row++;
          end
          default: begin
            screen_mirror[cur_row * COLUMNS + cur_col] = {r.color, r.char_code};
            cur_col++;
          end
        endcase
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // cursor never rests on the last row: scroll up, blank the bottom row
        if (cur_row >= ROWS - 1) begin
          for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_mirror[i] = screen_mirror[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_mirror[i] = '0;
          if (cur_row > 0) cur_row--;
          else cur_col = 0;
        end
      end
      ACT_CLEAR: begin
        foreach (screen_mirror[i]) screen_mirror[i] = '0;
        cur_col = 0;
        cur_row = 0;
      end
      ACT_READ: begin
        // out of range reads return a blank cell
        if (r.cell_index < CELLS) begin
          res.ch   = screen_mirror[r.cell_index][CHAR_W-1:0];
          res.colr = screen_mirror[r.cell_index][CELL_W-1:CHAR_W];
        end
      end
      default: ;  // unused action: only the cursor is reported
    endcase
    res.pos = POS_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes requests from req_q. A request is predicted at the edge at
  // which the engine accepts it. The gap before each request is drawn at
  // random, with stretches of back-to-back traffic every 128 requests.
  // ---------------------------------------------------------------------------
  console_req_t cur_req;
  int           send_gap;
  int           sent_count;
  bit           send_burst;
  bit           launch;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_valid  <= 1'b0;
      send_gap   = 0;
      sent_count = 0;
      send_burst = 1'b0;
    end else begin
      launch = 1'b0;
      if (req_valid && in_bus.ready) begin
        cursor_exp_q.push_back(console_apply(cur_req));
        sent_count++;
        if (sent_count % 128 == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 3);
      end
      if (!req_valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_q.size() > 0 &&
                     !(req_q[0].drain && cursor_exp_q.size() != 0)) begin
          cur_req = req_q.pop_front();
          launch  = 1'b1;
        end
      end
      if (launch) begin
        req_action <= cur_req.action;
        req_char   <= cur_req.char_code;
        req_color  <= cur_req.color;
        req_index  <= cur_req.cell_index;
        req_valid  <= 1'b1;
      end else if (!req_valid || in_bus.ready) begin
        req_valid  <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: after each response the ready line may drop for a randomly drawn
  // stall, with no stalls for stretches of 96 responses at a time.
  // ---------------------------------------------------------------------------
  console_resp_t got;
  console_resp_t want;
  int            stall_left;
  int            rsp_count;
  bit            rsp_burst;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_ready  <= 1'b0;
      stall_left = 0;
      rsp_count  = 0;
      rsp_burst  = 1'b0;
    end else begin
      if (out_bus.valid && rsp_ready) begin
        got = {out_bus.cursor_pos, out_bus.cell_char, out_bus.cell_color};
        if (cursor_exp_q.size() == 0) begin
          flag_error($sformatf("unexpected response: pos %0d char %02h colour %02h",
                               got.pos, got.ch, got.colr));
        end else begin
          want = cursor_exp_q.pop_front();
          if (got.pos !== want.pos || got.ch !== want.ch || got.colr !== want.colr)
            flag_error($sformatf(
              "response %0d: pos %0d/%0d char %02h/%02h colour %02h/%02h (exp/act)",
              rsp_count, want.pos, got.pos, want.ch, got.ch, want.colr, got.colr));
        end
        rsp_count++;
        if (rsp_count % 96 == 0) rsp_burst = !rsp_burst;
        stall_left = rsp_burst ? 0 : $urandom_range(0, 3);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      rsp_ready <= (stall_left == 0);
    end
  end

  // Watchdog: too long without a handshake on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_valid && in_bus.ready) || (out_bus.valid && rsp_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic console_req_t mk_req(input tcce_action_e a,
                                          input logic [CHAR_W-1:0] c,
                                          input logic [COLOR_W-1:0] colr,
                                          input int idx,
                                          input bit drain);
    console_req_t r;
    r.action     = a;
    r.char_code  = c;
    r.color      = colr;
    r.cell_index = IDX_W'(idx);
    r.drain      = drain;
    return r;
  endfunction

  task automatic queue_req(input console_req_t r);
    while (req_q.size() >= REQ_DEPTH) @(posedge clk);
    req_q.push_back(r);
  endtask

  initial begin
    console_req_t r;
    int           pick;
    int           pos;
    int           back;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: blank store, extremes of character and colour, backspace
    // keeping the colour byte, backspace at column zero, unused action,
    // return, newline, tab wrapping past the last column, and reads at the
    // top of the index range.
    queue_req(mk_req(ACT_READ,  8'h00, 8'h00, 0, 1'b0));
    queue_req(mk_req(ACT_PUT,   8'h41, 8'hFF, 0, 1'b0));
    queue_req(mk_req(ACT_PUT,   8'hFF, 8'h00, 0, 1'b0));
    queue_req(mk_req(ACT_PUT,   8'h00, 8'h5A, 0, 1'b0));
    queue_req(mk_req(ACT_PUT,   CH_BS, 8'hFF, 2047, 1'b0));
    queue_req(mk_req(ACT_READ,  8'h00, 8'h00, 2, 1'b0));
    queue_req(mk_req(ACT_PUT,   CH_BS, 8'h00, 0, 1'b0));
    queue_req(mk_req(ACT_PUT,   CH_BS, 8'h00, 0, 1'b0));
    queue_req(mk_req(ACT_PUT,   CH_BS, 8'h00, 0, 1'b0));  // already at column 0
    queue_req(mk_req(ACT_READ,  8'hFF, 8'hFF, 0, 1'b0));
    queue_req(mk_req(ACT_NONE,  8'hFF, 8'hFF, 2047, 1'b0));
    queue_req(mk_req(ACT_PUT,   8'h7E, 8'h81, 0, 1'b0));
    queue_req(mk_req(ACT_PUT,   CH_CR, 8'h00, 0, 1'b0));
    queue_req(mk_req(ACT_PUT,   CH_LF, 8'h00, 0, 1'b0));
    for (int i = 0; i < COLUMNS / TAB_WIDTH; i++)
      queue_req(mk_req(ACT_PUT, CH_TAB, 8'h00, 0, 1'b0));
    queue_req(mk_req(ACT_READ,  8'h00, 8'h00, 2047, 1'b0));
    queue_req(mk_req(ACT_READ,  8'h00, 8'h00, CELLS - 1, 1'b0));
    queue_req(mk_req(ACT_CLEAR, 8'h00, 8'h00, 0, 1'b0));

    // Random: mostly text with the odd control character, enough newlines to
    // reach the scroll row and keep scrolling, reads near the cursor, and
    // rare clears. A pause for all responses every 300 requests.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      r.char_code  = CHAR_W'($urandom_range(0, 255));
      r.color      = COLOR_W'($urandom_range(0, 255));
      r.cell_index = IDX_W'($urandom_range(0, 2047));
      r.drain      = (n % 300 == 0);
      pick = $urandom_range(0, 999);
      if (pick < 5) begin
        r.action = ACT_CLEAR;
      end else if (pick < 20) begin
        r.action = ACT_NONE;
      end else if (pick < 270) begin
        r.action = ACT_READ;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          pos  = cur_row * COLUMNS + cur_col;
          back = $urandom_range(0, 2 * COLUMNS);
          r.cell_index = IDX_W'(pos > back ? pos - back : 0);
        end else if (pick < 8) begin
          r.cell_index = IDX_W'($urandom_range(0, CELLS - 1));
        end
      end else begin
        r.action = ACT_PUT;
        pick = $urandom_range(0, 99);
        if (pick < 8)       r.char_code = CH_BS;
        else if (pick < 14) r.char_code = CH_TAB;
        else if (pick < 18) r.char_code = CH_CR;
        else if (pick < 26) r.char_code = CH_LF;
      end
      queue_req(r);
    end

    // Drain, then give the engine time to show any stray response
    while (req_q.size() != 0 || req_valid || cursor_exp_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0 && cursor_exp_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_in_if.sv
hw/rtl/tcce_out_if.sv
hw/rtl/tcce_store.sv
hw/rtl/tcce_ctrl.sv
hw/rtl/text_console_cursor_engine.sv
tb/text_console_cursor_engine_tb.sv
